// ===== design/sequence_sorted_priority_queue_defines.svh =====
// Assertion macros for the sorted priority queue.
`ifndef SEQUENCE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SEQUENCE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define SSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/sspq_pkg.sv =====
// Types and constants shared by the sorted priority queue files.
package sspq_pkg;

	localparam int SSPQ_CAPACITY = 16;
	localparam int SSPQ_KEY_BITS = 32;
	localparam int SSPQ_TAG_BITS = 16;
	localparam int SSPQ_CNT_BITS = $clog2(SSPQ_CAPACITY + 1);

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_POPPED    = 3'd3,
		ST_POP_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [SSPQ_KEY_BITS-1:0] seq_key;
		logic [SSPQ_TAG_BITS-1:0] packet_tag;
	} in_item_t;

	typedef struct packed {
		status_t                  status;
		logic                     is_empty;
		logic [SSPQ_KEY_BITS-1:0] head_seq;
		logic [SSPQ_TAG_BITS-1:0] head_tag;
		logic [SSPQ_CNT_BITS-1:0] occupancy;
	} out_item_t;

	typedef struct packed {
		logic [SSPQ_KEY_BITS-1:0] key;
		logic [SSPQ_TAG_BITS-1:0] tag;
	} entry_t;

	// Operation broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins;
		logic                     pop;
		logic [SSPQ_KEY_BITS-1:0] key;
		logic [SSPQ_TAG_BITS-1:0] tag;
	} op_t;

endpackage

// ===== design/sequence_sorted_priority_queue.sv =====
// Top level of the sorted priority queue: input stage, cell chain, result register.
//
//  channel | direction | handshake                  | payload
//  item    | in        | item_valid / item_stall     | item   (cmd, seq_key, packet_tag)
//  result  | out       | result_valid / result_stall | result (status, is_empty, head,
//          |           |                            |         occupancy)
//
// One item per cycle sustained while the result is not stalled: every cell compares
// its key with the new key at once and shifts by one place, so an operation completes
// in the cycle it leaves the input stage. After the item transfer the item is held in
// the input stage, then its result in the result register.
// Reset empties the queue (cell valid bits and count); entry contents stay undefined.
// A stalled result holds the chain; one further item waits in the input stage.
`include "sequence_sorted_priority_queue_defines.svh"

module sequence_sorted_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sspq_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output sspq_pkg::out_item_t result
);
	import sspq_pkg::*;

	localparam int CAP = SSPQ_CAPACITY;

	in_item_t                 item_s1;
	logic                     item_vld_s1;
	out_item_t                result_q;
	logic                     result_valid_q;
	logic [SSPQ_CNT_BITS-1:0] count_q;
	logic [SSPQ_CNT_BITS-1:0] count_d;

	entry_t         cell_entry [CAP];
	logic [CAP-1:0] cell_valid;
	logic [CAP-1:0] cell_lt;
	logic [CAP-1:0] cell_eq;

	op_t     op;
	logic    adv;
	logic    fire;
	logic    dup;
	logic    full;
	logic    empty;
	logic    is_ins;
	status_t status_d;
	entry_t  head_d;

	assign adv        = !result_valid_q || !result_stall;
	assign fire       = adv && item_vld_s1;
	assign item_stall = item_vld_s1 && !adv;

	assign dup    = |cell_eq;
	assign full   = (count_q == SSPQ_CNT_BITS'(CAP));
	assign empty  = (count_q == '0);
	assign is_ins = (item_s1.cmd == CMD_INSERT);

	assign op.ins = fire && is_ins && !dup && !full;
	assign op.pop = fire && !is_ins && !empty;
	assign op.key = item_s1.seq_key;
	assign op.tag = item_s1.packet_tag;

	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			entry_t l_entry;
			logic   l_valid;
			logic   l_lt;
			entry_t r_entry;
			logic   r_valid;
			if (gi == 0) begin : g_first
				assign l_entry = '0;
				assign l_valid = 1'b0;
				assign l_lt    = 1'b1;
			end else begin : g_mid_l
				assign l_entry = cell_entry[gi-1];
				assign l_valid = cell_valid[gi-1];
				assign l_lt    = cell_lt[gi-1];
			end
			if (gi == CAP - 1) begin : g_last
				assign r_entry = '0;
				assign r_valid = 1'b0;
			end else begin : g_mid_r
				assign r_entry = cell_entry[gi+1];
				assign r_valid = cell_valid[gi+1];
			end
			sspq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (op),
				.left_entry  (l_entry),
				.left_valid  (l_valid),
				.left_lt     (l_lt),
				.right_entry (r_entry),
				.right_valid (r_valid),
				.entry       (cell_entry[gi]),
				.valid       (cell_valid[gi]),
				.lt          (cell_lt[gi]),
				.eq          (cell_eq[gi])
			);
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (op.ins) begin
			count_d = count_q + 1'b1;
		end else if (op.pop) begin
			count_d = count_q - 1'b1;
		end

		if (is_ins) begin
			status_d = dup ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
		end else begin
			status_d = empty ? ST_POP_EMPTY : ST_POPPED;
		end

		// head after the step: new key if it lands in front, next entry on pop
		if (op.ins && !cell_lt[0]) begin
			head_d = '{key: op.key, tag: op.tag};
		end else if (op.pop) begin
			head_d = cell_entry[1];
		end else begin
			head_d = cell_entry[0];
		end
		if (count_d == '0) begin
			head_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1    <= 1'b0;
			result_valid_q <= 1'b0;
			count_q        <= '0;
		end else begin
			if (!item_stall) begin
				item_vld_s1 <= item_valid;
			end
			if (adv) begin
				result_valid_q <= item_vld_s1;
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q.status    <= status_d;
			result_q.is_empty  <= (count_d == '0);
			result_q.head_seq  <= head_d.key;
			result_q.head_tag  <= head_d.tag;
			result_q.occupancy <= count_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SSPQ_ASSERT_NOW(a_occ_bound, clk, arst_n, result_valid, result.occupancy <= SSPQ_CNT_BITS'(CAP), "occupancy above capacity")
	`SSPQ_ASSERT_NOW(a_empty_flag, clk, arst_n, result_valid, result.is_empty == (result.occupancy == '0), "empty flag disagrees with occupancy")
	`SSPQ_ASSERT_NOW(a_chain_valid, clk, arst_n, 1'b1, cell_valid[0] == !empty, "head cell valid disagrees with count")
	`SSPQ_ASSERT_NEXT(a_pop_count, clk, arst_n, op.pop, count_q == $past(count_q) - 1'b1, "pop did not lower count")

endmodule

// ===== design/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
module sspq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sspq_pkg::op_t    op,
	input  sspq_pkg::entry_t left_entry,
	input  logic            left_valid,
	input  logic            left_lt,
	input  sspq_pkg::entry_t right_entry,
	input  logic            right_valid,
	output sspq_pkg::entry_t entry,
	output logic            valid,
	output logic            lt,
	output logic            eq
);
	import sspq_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	entry_t entry_d;
	logic   valid_d;

	assign lt = valid_q && (entry_q.key < op.key);
	assign eq = valid_q && (entry_q.key == op.key);
	assign entry = entry_q;
	assign valid = valid_q;

	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		if (op.ins && !lt) begin
			// first cell not below the key takes the new entry, the rest move right
			if (left_lt) begin
				entry_d = '{key: op.key, tag: op.tag};
				valid_d = 1'b1;
			end else begin
				entry_d = left_entry;
				valid_d = left_valid;
			end
		end else if (op.pop) begin
			entry_d = right_entry;
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
